// ===== rtl/rbs_pkg.sv =====
// Shared types for the ray versus box slab test pipeline.
// No dependencies; used by ray_box_slab_test.
package rbs_pkg;

    // Per-item flags that travel beside the dividers
    typedef struct packed {
        logic       in_box;  // origin strictly inside the box on every axis
        logic       miss;    // a zero-direction axis with the origin outside its slab
        logic [2:0] unb;     // axis sets no bound (zero direction component)
    } side_t;

endpackage

// ===== rtl/rbs_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, unsigned magnitudes.
// Stand-alone; instanced by ray_box_slab_test. The sign bit rides along.
module rbs_div #(
    parameter int CW = 32,
    parameter int NW = 49
) (
    input  logic          clk,
    input  logic          en,
    input  logic [NW-1:0] num,
    input  logic [CW-1:0] den,
    input  logic          neg,
    output logic [NW-1:0] quo,
    output logic          quo_neg
);

    logic [NW-1:0] num_reg [NW];
    logic [NW-1:0] q_reg   [NW];
    logic [CW-1:0] rem_reg [NW];
    logic [CW-1:0] den_reg [NW];
    logic          neg_reg [NW];

    genvar k;
    generate
        for (k = 0; k < NW; k++) begin : g_stage
            logic [NW-1:0] num_in;
            logic [NW-1:0] q_in;
            logic [CW-1:0] rem_in;
            logic [CW-1:0] den_in;
            logic          neg_in;
            logic [CW:0]   trial;
            logic          ge;
            logic [CW:0]   diff;

            if (k == 0) begin : g_first
                assign num_in = num;
                assign q_in   = '0;
                assign rem_in = '0;
                assign den_in = den;
                assign neg_in = neg;
            end else begin : g_next
                assign num_in = num_reg[k-1];
                assign q_in   = q_reg[k-1];
                assign rem_in = rem_reg[k-1];
                assign den_in = den_reg[k-1];
                assign neg_in = neg_reg[k-1];
            end

            // shift in the next numerator bit, subtract if it fits
            assign trial = {rem_in, num_in[NW-1]};
            assign ge    = (trial >= {1'b0, den_in});
            assign diff  = trial - {1'b0, den_in};

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    num_reg[k] <= num_in << 1;
                    q_reg[k]   <= {q_in[NW-2:0], ge};
                    rem_reg[k] <= ge ? diff[CW-1:0] : trial[CW-1:0];
                    den_reg[k] <= den_in;
                    neg_reg[k] <= neg_in;
                end
            end
        end
    endgenerate

    assign quo     = q_reg[NW-1];
    assign quo_neg = neg_reg[NW-1];

endmodule

// ===== rtl/ray_box_slab_test.sv =====
// Ray versus axis-aligned box test (slab method) on signed fixed-point inputs.
// Depends on rbs_pkg and rbs_div.
//
// One test is accepted per cycle while the pipeline is not held, and each gives
// one hit bit. Six pipelined dividers form the entry and exit distances one
// quotient bit per stage (COORD_WIDTH + FRAC_BITS + 1 stages), behind the input
// register; saturation, two interval-merge stages and the output register
// follow. A hit is reported when the origin is strictly inside the box, or
// when no zero-direction axis has the origin outside its slab, the per-axis
// entry/exit intervals overlap and the exit distance is positive (or no axis
// sets a bound). The whole pipeline holds while a result waits under out_stall;
// bubbles inside the pipeline are not squeezed out.
module ray_box_slab_test #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [COORD_WIDTH-1:0] origin_x,
    input  logic signed [COORD_WIDTH-1:0] origin_y,
    input  logic signed [COORD_WIDTH-1:0] origin_z,
    input  logic signed [COORD_WIDTH-1:0] dir_x,
    input  logic signed [COORD_WIDTH-1:0] dir_y,
    input  logic signed [COORD_WIDTH-1:0] dir_z,
    input  logic signed [COORD_WIDTH-1:0] box_lo_x,
    input  logic signed [COORD_WIDTH-1:0] box_lo_y,
    input  logic signed [COORD_WIDTH-1:0] box_lo_z,
    input  logic signed [COORD_WIDTH-1:0] box_hi_x,
    input  logic signed [COORD_WIDTH-1:0] box_hi_y,
    input  logic signed [COORD_WIDTH-1:0] box_hi_z,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          hit
);

    localparam int CW = COORD_WIDTH;
    localparam int NW = COORD_WIDTH + 1 + FRAC_BITS;

    logic adv;

    // input registers
    logic                 in_valid_reg;
    logic signed [CW-1:0] o_reg  [3];
    logic signed [CW-1:0] d_reg  [3];
    logic signed [CW-1:0] lo_reg [3];
    logic signed [CW-1:0] hi_reg [3];

    // output register
    logic out_valid_reg;
    logic hit_reg;

    assign adv      = !out_valid_reg || !out_stall;
    assign in_stall = !adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (adv)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            o_reg[0]  <= origin_x;  o_reg[1]  <= origin_y;  o_reg[2]  <= origin_z;
            d_reg[0]  <= dir_x;     d_reg[1]  <= dir_y;     d_reg[2]  <= dir_z;
            lo_reg[0] <= box_lo_x;  lo_reg[1] <= box_lo_y;  lo_reg[2] <= box_lo_z;
            hi_reg[0] <= box_hi_x;  hi_reg[1] <= box_hi_y;  hi_reg[2] <= box_hi_z;
        end
    end

    // per-axis setup, dividers and saturation
    logic [2:0]           ins_ax;
    logic [2:0]           miss_ax;
    logic [2:0]           zero_ax;
    logic [NW-1:0]        qn [3];
    logic [NW-1:0]        qf [3];
    logic                 qn_neg [3];
    logic                 qf_neg [3];
    logic signed [CW-1:0] tn_next [3];
    logic signed [CW-1:0] tf_next [3];

    genvar k;
    generate
        for (k = 0; k < 3; k++) begin : g_axis
            logic                 dneg;
            logic signed [CW-1:0] pn;
            logic signed [CW-1:0] pf;
            logic signed [CW:0]   dn;
            logic signed [CW:0]   df;
            logic [CW:0]          mag_n;
            logic [CW:0]          mag_f;
            logic [CW-1:0]        den;
            logic [NW-1:0]        lim_n;
            logic [NW-1:0]        lim_f;
            logic [NW-1:0]        sat_n;
            logic [NW-1:0]        sat_f;

            assign zero_ax[k] = (d_reg[k] == '0);
            assign ins_ax[k]  = (o_reg[k] > lo_reg[k]) && (o_reg[k] < hi_reg[k]);
            assign miss_ax[k] = zero_ax[k] &&
                                ((o_reg[k] < lo_reg[k]) || (o_reg[k] > hi_reg[k]));

            // near plane is the low corner unless the direction is negative
            assign dneg  = d_reg[k][CW-1];
            assign pn    = dneg ? hi_reg[k] : lo_reg[k];
            assign pf    = dneg ? lo_reg[k] : hi_reg[k];
            assign dn    = {pn[CW-1], pn} - {o_reg[k][CW-1], o_reg[k]};
            assign df    = {pf[CW-1], pf} - {o_reg[k][CW-1], o_reg[k]};
            assign mag_n = dn[CW] ? (CW+1)'(-dn) : (CW+1)'(dn);
            assign mag_f = df[CW] ? (CW+1)'(-df) : (CW+1)'(df);
            assign den   = dneg ? CW'(-d_reg[k]) : CW'(d_reg[k]);

            rbs_div #(.CW(CW), .NW(NW)) u_div_n (
                .clk     (clk),
                .en      (adv),
                .num     (NW'(mag_n) << FRAC_BITS),
                .den     (den),
                .neg     (dn[CW] ^ dneg),
                .quo     (qn[k]),
                .quo_neg (qn_neg[k])
            );

            rbs_div #(.CW(CW), .NW(NW)) u_div_f (
                .clk     (clk),
                .en      (adv),
                .num     (NW'(mag_f) << FRAC_BITS),
                .den     (den),
                .neg     (df[CW] ^ dneg),
                .quo     (qf[k]),
                .quo_neg (qf_neg[k])
            );

            // clamp to the signed range, then apply the sign
            assign lim_n = (NW'(1) << (CW-1)) - (qn_neg[k] ? NW'(0) : NW'(1));
            assign lim_f = (NW'(1) << (CW-1)) - (qf_neg[k] ? NW'(0) : NW'(1));
            assign sat_n = (qn[k] > lim_n) ? lim_n : qn[k];
            assign sat_f = (qf[k] > lim_f) ? lim_f : qf[k];
            assign tn_next[k] = qn_neg[k] ? -$signed(sat_n[CW-1:0]) : $signed(sat_n[CW-1:0]);
            assign tf_next[k] = qf_neg[k] ? -$signed(sat_f[CW-1:0]) : $signed(sat_f[CW-1:0]);
        end
    endgenerate

    // flags delay line matching the divider depth
    rbs_pkg::side_t side_in;
    rbs_pkg::side_t side_reg [NW];
    logic           sv_reg   [NW];

    assign side_in.in_box = &ins_ax;
    assign side_in.miss   = |miss_ax;
    assign side_in.unb    = zero_ax;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NW; i++)
                sv_reg[i] <= 1'b0;
        end
        else if (adv)
        begin
            sv_reg[0] <= in_valid_reg;
            for (int i = 1; i < NW; i++)
                sv_reg[i] <= sv_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_reg[0] <= side_in;
            for (int i = 1; i < NW; i++)
                side_reg[i] <= side_reg[i-1];
        end
    end

    // saturated distances
    logic                 sat_valid_reg;
    rbs_pkg::side_t       sat_side_reg;
    logic signed [CW-1:0] tn_reg [3];
    logic signed [CW-1:0] tf_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sat_valid_reg <= 1'b0;
        else if (adv)
            sat_valid_reg <= sv_reg[NW-1];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sat_side_reg <= side_reg[NW-1];
            for (int i = 0; i < 3; i++)
            begin
                tn_reg[i] <= tn_next[i];
                tf_reg[i] <= tf_next[i];
            end
        end
    end

    // merge x and y intervals
    logic                 c1_valid_reg;
    rbs_pkg::side_t       c1_side_reg;
    logic                 c1_bnd_reg, c1_bnd_next;
    logic                 c1_disj_reg, c1_disj_next;
    logic signed [CW-1:0] c1_n_reg, c1_n_next;
    logic signed [CW-1:0] c1_f_reg, c1_f_next;

    always_comb
    begin
        c1_bnd_next  = !(sat_side_reg.unb[0] && sat_side_reg.unb[1]);
        c1_disj_next = 1'b0;
        c1_n_next    = tn_reg[0];
        c1_f_next    = tf_reg[0];
        if (sat_side_reg.unb[0])
        begin
            c1_n_next = tn_reg[1];
            c1_f_next = tf_reg[1];
        end
        else if (!sat_side_reg.unb[1])
        begin
            c1_disj_next = (tn_reg[0] > tf_reg[1]) || (tn_reg[1] > tf_reg[0]);
            c1_n_next    = (tn_reg[1] > tn_reg[0]) ? tn_reg[1] : tn_reg[0];
            c1_f_next    = (tf_reg[1] < tf_reg[0]) ? tf_reg[1] : tf_reg[0];
        end
    end

    // z interval carried alongside
    logic signed [CW-1:0] zn_reg;
    logic signed [CW-1:0] zf_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            c1_valid_reg <= 1'b0;
        else if (adv)
            c1_valid_reg <= sat_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c1_side_reg <= sat_side_reg;
            c1_bnd_reg  <= c1_bnd_next;
            c1_disj_reg <= c1_disj_next;
            c1_n_reg    <= c1_n_next;
            c1_f_reg    <= c1_f_next;
            zn_reg      <= tn_reg[2];
            zf_reg      <= tf_reg[2];
        end
    end

    // merge z interval
    logic                 c2_valid_reg;
    logic                 c2_inside_reg;
    logic                 c2_miss_reg;
    logic                 c2_bnd_reg, c2_bnd_next;
    logic                 c2_disj_reg, c2_disj_next;
    logic signed [CW-1:0] c2_f_reg, c2_f_next;

    always_comb
    begin
        c2_bnd_next  = c1_bnd_reg || !c1_side_reg.unb[2];
        c2_disj_next = c1_disj_reg;
        c2_f_next    = c1_f_reg;
        if (!c1_bnd_reg)
            c2_f_next = zf_reg;
        else if (!c1_side_reg.unb[2])
        begin
            c2_disj_next = c1_disj_reg || (c1_n_reg > zf_reg) || (zn_reg > c1_f_reg);
            c2_f_next    = (zf_reg < c1_f_reg) ? zf_reg : c1_f_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            c2_valid_reg <= 1'b0;
        else if (adv)
            c2_valid_reg <= c1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c2_inside_reg <= c1_side_reg.in_box;
            c2_miss_reg   <= c1_side_reg.miss;
            c2_bnd_reg    <= c2_bnd_next;
            c2_disj_reg   <= c2_disj_next;
            c2_f_reg      <= c2_f_next;
        end
    end

    // final decision and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= c2_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            hit_reg <= c2_inside_reg ||
                       (!c2_miss_reg && !c2_disj_reg && (!c2_bnd_reg || (c2_f_reg > 0)));
    end

    assign out_valid = out_valid_reg;
    assign hit       = hit_reg;

    // the input side only holds while a finished result is waiting
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid_reg && out_stall))
        else $error("input stalled without a blocked result");

    // a new result comes only from the last merge stage
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(c2_valid_reg))
        else $error("result appeared without a merged item");

    // an item inside the box always reports a hit
    a_inside_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && c2_valid_reg && c2_inside_reg) |=> hit_reg)
        else $error("inside origin did not report a hit");

endmodule
